>>> hdl/bsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared constants and types for the byte-stuffing framer: the flag and
// escape bytes, and the plan that the front end hands to the back end.
// ----------------------------------------------------------------------------
package bsf_pkg;

    // Framing constants.
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Direction register codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Most output words one input word can cause.
    localparam int MAX_RUN = 4;
    localparam int RUN_IDX_W = $clog2(MAX_RUN);
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    // Depth of the plan queue between front and back end.
    localparam int PLAN_DEPTH = 2;
    localparam int PLAN_PTR_W = $clog2(PLAN_DEPTH);
    localparam int PLAN_CNT_W = $clog2(PLAN_DEPTH + 1);

    // One classified input word: the bytes to emit, how many, and whether
    // the final one closes the frame.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
        logic                    fend;
    } plan_t;

    // Head of the plan queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        plan_t plan;
    } plan_head_t;

endpackage

>>> hdl/byte_stuff_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuff_framer
// Byte-stuffing framer with encode and decode directions.
// ----------------------------------------------------------------------------
// The block takes one input word per cycle while full is low and gives out one
// output word per cycle while the consumer pops. An input word can cause zero
// to four output words; the back end emits them one per cycle while the output
// register is drained, and the input side stalls (full) only when the two-entry
// plan queue is taken up. Words that yield one output each stream at one per
// cycle while pop stays high. The first output word of an input word passes
// through the plan queue and the output register before it reaches the output
// ports. Write the direction register only while no words are in flight.
// ----------------------------------------------------------------------------
module byte_stuff_framer
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       first_of_frame,
    input  logic       last_of_frame,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       run_last
);

    logic       accept;
    logic       plan_we;
    plan_t      plan;
    plan_head_t head;
    logic       head_pop;

    assign accept = push && !full;

    // Front end.
    bsf_classify u_classify (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .data_byte      (data_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .accept         (accept),
        .plan_we        (plan_we),
        .plan           (plan)
    );

    // Plan queue.
    bsf_plan_fifo u_plan_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (plan_we),
        .wr_plan (plan),
        .full    (full),
        .rd_en   (head_pop),
        .head    (head)
    );

    // Back end.
    bsf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_pop  (head_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .run_last  (run_last)
    );

endmodule

>>> hdl/bsf_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_classify
// Front end: accepts input words, holds the direction register and the
// decode escape state, and turns each word into a plan of output bytes.
// ----------------------------------------------------------------------------
module bsf_classify
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic [7:0] data_byte,
    input  logic       first_of_frame,
    input  logic       last_of_frame,
    input  logic       accept,
    output logic       plan_we,
    output plan_t      plan
);

    logic direction_reg;
    logic esc_reg;
    logic esc_next;

    // Direction register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
        end
        else if (cfg_we)
        begin
            direction_reg <= cfg_wdata;
        end
    end

    // Build the plan for the current input word and the next escape state.
    always_comb
    begin
        logic [RUN_CNT_W-1:0] n;
        n = '0;
        plan.bytes = '0;
        esc_next = esc_reg;
        if (direction_reg == DIR_ENCODE)
        begin
            if (first_of_frame)
            begin
                plan.bytes[n[RUN_IDX_W-1:0]] = FLAG_BYTE;
                n = n + 1'b1;
            end
            if (data_byte == FLAG_BYTE || data_byte == ESC_BYTE)
            begin
                plan.bytes[n[RUN_IDX_W-1:0]] = ESC_BYTE;
                n = n + 1'b1;
                plan.bytes[n[RUN_IDX_W-1:0]] = data_byte ^ ESC_XOR;
                n = n + 1'b1;
            end
            else
            begin
                plan.bytes[n[RUN_IDX_W-1:0]] = data_byte;
                n = n + 1'b1;
            end
            if (last_of_frame)
            begin
                plan.bytes[n[RUN_IDX_W-1:0]] = FLAG_BYTE;
                n = n + 1'b1;
            end
        end
        else
        begin
            if (first_of_frame)
            begin
                esc_next = 1'b0;
            end
            else if (esc_reg)
            begin
                plan.bytes[n[RUN_IDX_W-1:0]] = data_byte ^ ESC_XOR;
                n = n + 1'b1;
                esc_next = 1'b0;
            end
            else if (!last_of_frame)
            begin
                if (data_byte == ESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    plan.bytes[n[RUN_IDX_W-1:0]] = data_byte;
                    n = n + 1'b1;
                end
            end
            if (last_of_frame)
            begin
                // Terminator byte is zero.
                plan.bytes[n[RUN_IDX_W-1:0]] = 8'h00;
                n = n + 1'b1;
                esc_next = 1'b0;
            end
        end
        plan.cnt = n;
        plan.fend = last_of_frame;
    end

    // A word that yields no output is absorbed here and never queued.
    assign plan_we = accept && (plan.cnt != '0);

    // Escape state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else if (accept)
        begin
            esc_reg <= esc_next;
        end
    end

    // A closing word in the decode direction always leaves no escape pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_of_frame && direction_reg == DIR_DECODE) |=> !esc_reg)
        else $error("escape pending after frame close");

    // Encoding never touches the escape state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && direction_reg == DIR_ENCODE) |=> esc_reg == $past(esc_reg))
        else $error("escape state changed while encoding");

endmodule

>>> hdl/bsf_plan_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_plan_fifo
// Short queue of plans between the front end and the back end.
// ----------------------------------------------------------------------------
module bsf_plan_fifo
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  plan_t      wr_plan,
    output logic       full,
    input  logic       rd_en,
    output plan_head_t head
);

    plan_t                 mem_reg [PLAN_DEPTH];
    logic [PLAN_PTR_W-1:0] wr_ptr_reg;
    logic [PLAN_PTR_W-1:0] rd_ptr_reg;
    logic [PLAN_CNT_W-1:0] count_reg;

    assign full       = (count_reg == PLAN_CNT_W'(PLAN_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.plan  = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_plan;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PLAN_PTR_W'(PLAN_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PLAN_PTR_W'(PLAN_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + PLAN_CNT_W'(wr_en) - PLAN_CNT_W'(rd_en);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PLAN_CNT_W'(PLAN_DEPTH))
        else $error("plan queue overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> head.valid)
        else $error("plan queue read while empty");

endmodule

>>> hdl/bsf_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsf_emit
// Back end: walks head plans one byte per free cycle into an output register.
// ----------------------------------------------------------------------------
module bsf_emit
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  plan_head_t head,
    output logic       head_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       run_last
);

    logic                 out_valid_reg;
    logic [7:0]           byte_reg;
    logic                 fend_reg;
    logic                 last_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 load;
    logic                 is_last;

    // The output register takes a new word when it is free or being drained.
    assign load     = head.valid && (!out_valid_reg || pop);
    assign is_last  = ({1'b0, idx_reg} == head.plan.cnt - 1'b1);
    assign head_pop = load && is_last;

    // Byte position within the current plan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (load)
        begin
            idx_reg <= is_last ? '0 : idx_reg + 1'b1;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head.plan.bytes[idx_reg];
            fend_reg <= is_last && head.plan.fend;
            last_reg <= is_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = byte_reg;
    assign frame_end = fend_reg;
    assign run_last  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> ({1'b0, idx_reg} < head.plan.cnt))
        else $error("emit position beyond plan length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end) |-> run_last)
        else $error("frame end not on the last word of its run");

endmodule
